// ===== design/stepper_homing_sequencer_assert.svh =====
// Assertion macros used by the checker file of the homing sequencer.
`ifndef STEPPER_HOMING_SEQUENCER_ASSERT_SVH
`define STEPPER_HOMING_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hsq_pkg.sv =====
// Package with the types and constants of the stepper homing sequencer.
package hsq_pkg;

  localparam logic [1:0] DEBOUNCE_READS = 2'd3;
  localparam logic [1:0] DebounceMax    = 2'd3;

  typedef enum logic [2:0] {
    PH_SEEK  = 3'd0,
    PH_STAB  = 3'd1,
    PH_OFFS  = 3'd2,
    PH_DONE  = 3'd3,
    PH_FAULT = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_HOMING = 2'd0,
    ST_READY  = 2'd1,
    ST_FAULT  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_HOME_SPEED       = 3'd0,
    CFG_SWITCH_DISTANCE  = 3'd1,
    CFG_TIMEOUT_DISTANCE = 3'd2,
    CFG_SETTLE_TIME      = 3'd3,
    CFG_OFFSET_DISTANCE  = 3'd4,
    CFG_OFFSET_FORWARD   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [19:0] home_speed;
    logic [31:0] switch_distance;
    logic [31:0] timeout_distance;
    logic [15:0] settle_time;
    logic [31:0] offset_distance;
    logic        offset_forward;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic               sensor_active;
    logic signed [31:0] step_position;
    logic        [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [19:0] speed_goal;
    logic        dir_master;
    logic [2:0]  phase_out;
    logic [1:0]  sys_status;
    logic        set_zero;
    logic        clear_motion;
    logic        completed;
    logic [31:0] faults_seen;
  } out_item_t;

endpackage

// ===== design/stepper_homing_sequencer.sv =====
// Stepper homing sequencer top level: input register, homing core, result register.
// Each item passes through the input register and then the result register before it transfers.
// Throughput: one item per cycle while the result register is not stalled, limited by the single result register.
// The input register holds an item while the result register is full and stalled.
// Reset clears both valid flags, loads the default configuration and
// returns the sequence to seek with zero baselines and no faults counted.
module stepper_homing_sequencer
  import hsq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      out_free;
  logic      step;
  cfg_t      cfg;
  out_item_t result;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  hsq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hsq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== design/hsq_cfg.sv =====
// Configuration register file of the homing sequencer.
module hsq_cfg
  import hsq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HOME_SPEED:       cfg_d.home_speed       = cfg_data_i[19:0];
        CFG_SWITCH_DISTANCE:  cfg_d.switch_distance  = cfg_data_i;
        CFG_TIMEOUT_DISTANCE: cfg_d.timeout_distance = cfg_data_i;
        CFG_SETTLE_TIME:      cfg_d.settle_time      = cfg_data_i[15:0];
        CFG_OFFSET_DISTANCE:  cfg_d.offset_distance  = cfg_data_i;
        CFG_OFFSET_FORWARD:   cfg_d.offset_forward   = cfg_data_i[0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.home_speed       <= 20'd0;
      cfg_q.switch_distance  <= 32'd200;
      cfg_q.timeout_distance <= 32'd400;
      cfg_q.settle_time      <= 16'd500;
      cfg_q.offset_distance  <= 32'd0;
      cfg_q.offset_forward   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/hsq_core.sv =====
// Homing state machine: sequence state and the result of one item.
module hsq_core
  import hsq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] local_base_q, local_base_d;
  logic [31:0] first_base_q, first_base_d;
  logic        found_q, found_d;
  logic        tried_q, tried_d;
  logic [31:0] settle_start_q, settle_start_d;
  logic [1:0]  db_count_q, db_count_d;
  logic        dir_q, dir_d;
  logic [31:0] fault_total_q, fault_total_d;
  logic        zero_done_q, zero_done_d;

  logic [19:0] speed;
  status_e     status;
  logic        zero_pulse;
  logic        clear;
  logic [31:0] dist_local;
  logic [31:0] dist_first;
  logic [31:0] elapsed;
  logic        settled;

  function automatic logic [31:0] abs_dist(logic signed [31:0] pos, logic [31:0] base);
    logic [32:0] diff;
    logic [32:0] neg;
    diff = {pos[31], pos} - {base[31], base};
    neg  = ~diff + 33'd1;
    return diff[32] ? neg[31:0] : diff[31:0];
  endfunction

  assign dist_local = abs_dist(item_i.step_position, local_base_q);
  assign dist_first = abs_dist(item_i.step_position, first_base_q);
  assign elapsed    = item_i.time_ms - settle_start_q;
  assign settled    = elapsed >= {16'd0, cfg_i.settle_time};

  always_comb begin
    phase_d        = phase_q;
    local_base_d   = local_base_q;
    first_base_d   = first_base_q;
    found_d        = found_q;
    tried_d        = tried_q;
    settle_start_d = settle_start_q;
    db_count_d     = db_count_q;
    dir_d          = dir_q;
    fault_total_d  = fault_total_q;
    zero_done_d    = zero_done_q;
    speed          = 20'd0;
    status         = ST_HOMING;
    zero_pulse     = 1'b0;
    clear          = 1'b0;
    if (item_i.mode) begin
      phase_d        = PH_SEEK;
      local_base_d   = item_i.step_position;
      first_base_d   = item_i.step_position;
      found_d        = 1'b0;
      settle_start_d = 32'd0;
      tried_d        = 1'b0;
      dir_d          = 1'b0;
      db_count_d     = 2'd0;
      zero_done_d    = 1'b0;
      speed          = cfg_i.home_speed;
      clear          = 1'b1;
    end else begin
      unique case (phase_q)
        PH_SEEK: begin
          speed = cfg_i.home_speed;
          if (item_i.sensor_active) begin
            if (db_count_q != DebounceMax) begin
              db_count_d = db_count_q + 2'd1;
            end
            if (db_count_d >= DEBOUNCE_READS) begin
              found_d        = 1'b1;
              phase_d        = PH_STAB;
              settle_start_d = item_i.time_ms;
              speed          = 20'd0;
            end
          end else begin
            db_count_d = 2'd0;
          end
          if (!found_d && !tried_q && (dist_local > cfg_i.switch_distance)) begin
            tried_d      = 1'b1;
            local_base_d = item_i.step_position;
            dir_d        = 1'b1;
          end
          if (!found_d && (dist_first > cfg_i.timeout_distance)) begin
            phase_d = PH_FAULT;
            speed   = 20'd0;
            status  = ST_FAULT;
            if (fault_total_q != '1) begin
              fault_total_d = fault_total_q + 32'd1;
            end
          end
        end
        PH_STAB: begin
          if (settled && found_q) begin
            phase_d      = PH_OFFS;
            local_base_d = item_i.step_position;
            dir_d        = cfg_i.offset_forward;
          end
        end
        PH_OFFS: begin
          speed = cfg_i.home_speed;
          if (dist_local >= cfg_i.offset_distance) begin
            phase_d        = PH_DONE;
            settle_start_d = item_i.time_ms;
            speed          = 20'd0;
          end
        end
        PH_DONE: begin
          if (zero_done_q) begin
            status = ST_READY;
          end else if (settled) begin
            zero_done_d = 1'b1;
            zero_pulse  = 1'b1;
            clear       = 1'b1;
            status      = ST_READY;
          end
        end
        default: begin
          phase_d = PH_FAULT;
          clear   = 1'b1;
          status  = ST_FAULT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_SEEK;
      local_base_q   <= 32'd0;
      first_base_q   <= 32'd0;
      found_q        <= 1'b0;
      tried_q        <= 1'b0;
      settle_start_q <= 32'd0;
      db_count_q     <= 2'd0;
      dir_q          <= 1'b0;
      fault_total_q  <= 32'd0;
      zero_done_q    <= 1'b0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      local_base_q   <= local_base_d;
      first_base_q   <= first_base_d;
      found_q        <= found_d;
      tried_q        <= tried_d;
      settle_start_q <= settle_start_d;
      db_count_q     <= db_count_d;
      dir_q          <= dir_d;
      fault_total_q  <= fault_total_d;
      zero_done_q    <= zero_done_d;
    end
  end

  always_comb begin
    result_o.speed_goal   = speed;
    result_o.dir_master   = dir_d;
    result_o.phase_out    = phase_d;
    result_o.sys_status   = status;
    result_o.set_zero     = zero_pulse;
    result_o.clear_motion = clear;
    result_o.completed    = (phase_d == PH_DONE) || (phase_d == PH_FAULT);
    result_o.faults_seen  = fault_total_d;
  end

endmodule

// ===== design/hsq_checker.sv =====
// Port-level checker of the homing sequencer and its bind statement.
`include "stepper_homing_sequencer_assert.svh"

module hsq_checker
  import hsq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  `HSQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "Stalled result transfer changed.")

  `HSQ_ASSERT_IMPL(a_completed, clk_i, rst_ni, out_valid_o, out_item_o.completed == ((out_item_o.phase_out == PH_DONE) || (out_item_o.phase_out == PH_FAULT)), "Completed flag disagrees with phase.")

  `HSQ_ASSERT_IMPL(a_set_zero, clk_i, rst_ni, out_valid_o && out_item_o.set_zero, (out_item_o.phase_out == PH_DONE) && (out_item_o.sys_status == ST_READY) && out_item_o.clear_motion, "Set-zero pulse outside a ready done phase.")

  `HSQ_ASSERT_IMPL(a_still, clk_i, rst_ni, out_valid_o && ((out_item_o.phase_out == PH_STAB) || (out_item_o.phase_out == PH_DONE) || (out_item_o.phase_out == PH_FAULT)), out_item_o.speed_goal == 20'd0, "Motor commanded to move while holding still.")

endmodule

bind stepper_homing_sequencer hsq_checker u_hsq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
